// File: rtl/dvru_pkg.sv
package dvru_pkg;

    localparam int unsigned ADDR_BITS = 32;
    localparam int unsigned COST_BITS = 5;
    localparam logic [COST_BITS-1:0] COST_INF = 5'd16;
    localparam logic [COST_BITS-1:0] COST_HOP = 5'd1;

    typedef enum logic [2:0] {
        ACT_UNCHANGED = 3'd0,
        ACT_REPLACED  = 3'd1,
        ACT_REFRESHED = 3'd2,
        ACT_INSERTED  = 3'd3,
        ACT_DROPPED   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_INSERT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] dst;
        logic [ADDR_BITS-1:0] next_hop;
        logic [ADDR_BITS-1:0] iface;
        logic [COST_BITS-1:0] cost;
    } route_entry_t;

endpackage

// File: rtl/dvru_if.sv
interface dvru_in_if;
    logic        valid;
    logic        ready;
    logic        new_round;
    logic [31:0] dst_addr;
    logic [4:0]  adv_cost;
    logic [31:0] neighbor_addr;
    logic [31:0] local_iface_addr;

    modport source (
        output valid, new_round, dst_addr, adv_cost, neighbor_addr, local_iface_addr,
        input  ready
    );
    modport sink (
        input  valid, new_round, dst_addr, adv_cost, neighbor_addr, local_iface_addr,
        output ready
    );
endinterface

interface dvru_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [5:0]  entry_index;
    logic [31:0] entry_next_hop;
    logic [31:0] entry_iface;
    logic [4:0]  entry_cost;
    logic        round_changed;

    modport source (
        output valid, action, entry_index, entry_next_hop, entry_iface, entry_cost,
               round_changed,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_next_hop, entry_iface, entry_cost,
               round_changed,
        output ready
    );
endinterface

// File: rtl/distance_vector_route_update_unit.sv
// Distance-vector route table update unit.
// The route_in channel takes one advertised route per item: destination,
// the neighbor's cost, the neighbor's address and the receiving interface.
// The route_out channel returns one item per input item with the action
// taken, the affected slot and its contents after the update, and the
// sticky round change flag.
// The table is a single-port memory of TABLE_DEPTH entries that is scanned
// one entry per cycle by one shared address comparator. With n entries in
// the table, the scan stops at the first slot whose destination matches,
// or after all n filled slots on a miss; the item then passes through the
// update or insert state to the output register.
// Only one item is in flight: route_in is not ready from acceptance until
// the result item has been taken. When the receiver stalls, the result is
// held in its output register and the block waits.
// Reset empties the table and clears the change flag at once; the memory
// itself is not cleared, since only filled slots are ever read.
module distance_vector_route_update_unit #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input logic        clk,
    input logic        rst_n,
    dvru_in_if.sink    route_in,
    dvru_out_if.source route_out
);
    import dvru_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    route_entry_t table_mem [TABLE_DEPTH];
    route_entry_t entry_rd_reg;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  flag_reg, flag_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;

    logic [ADDR_BITS-1:0]  dst_reg, dst_next;
    logic [ADDR_BITS-1:0]  nbr_reg, nbr_next;
    logic [ADDR_BITS-1:0]  ifc_reg, ifc_next;
    logic [COST_BITS-1:0]  cand_reg, cand_next;

    action_t               act_reg, act_next;
    logic [5:0]            idx_reg, idx_next;
    logic [ADDR_BITS-1:0]  nh_out_reg, nh_out_next;
    logic [ADDR_BITS-1:0]  ifc_out_reg, ifc_out_next;
    logic [COST_BITS-1:0]  cost_out_reg, cost_out_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    route_entry_t          mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic                  dst_hit;

    assign dst_hit = (entry_rd_reg.dst == dst_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            entry_rd_reg <= table_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            scan_reg      <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        dst_reg      <= dst_next;
        nbr_reg      <= nbr_next;
        ifc_reg      <= ifc_next;
        cand_reg     <= cand_next;
        act_reg      <= act_next;
        idx_reg      <= idx_next;
        nh_out_reg   <= nh_out_next;
        ifc_out_reg  <= ifc_out_next;
        cost_out_reg <= cost_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        dst_next       = dst_reg;
        nbr_next       = nbr_reg;
        ifc_next       = ifc_reg;
        cand_next      = cand_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        nh_out_next    = nh_out_reg;
        ifc_out_next   = ifc_out_reg;
        cost_out_next  = cost_out_reg;
        mem_we         = 1'b0;
        mem_waddr      = cmp_idx_reg;
        mem_wdata      = entry_rd_reg;
        mem_re         = 1'b0;
        mem_raddr      = scan_reg[IDX_W-1:0];
        route_in.ready  = 1'b0;
        route_out.valid = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                route_in.ready = 1'b1;
                if (route_in.valid)
                begin
                    dst_next = route_in.dst_addr;
                    nbr_next = route_in.neighbor_addr;
                    ifc_next = route_in.local_iface_addr;
                    if (route_in.adv_cost >= COST_INF)
                    begin
                        cand_next = COST_INF;
                    end
                    else
                    begin
                        cand_next = route_in.adv_cost + COST_HOP;
                    end
                    if (route_in.new_round)
                    begin
                        flag_next = 1'b0;
                    end
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (cmp_valid_reg && dst_hit)
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = ST_UPDATE;
                end
                else if (scan_reg < count_reg)
                begin
                    mem_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = ST_INSERT;
                end
            end

            ST_UPDATE:
            begin
                idx_next      = 6'(cmp_idx_reg);
                act_next      = ACT_UNCHANGED;
                nh_out_next   = entry_rd_reg.next_hop;
                ifc_out_next  = entry_rd_reg.iface;
                cost_out_next = entry_rd_reg.cost;
                if (cand_reg < entry_rd_reg.cost)
                begin
                    mem_we             = 1'b1;
                    mem_wdata.next_hop = nbr_reg;
                    mem_wdata.iface    = ifc_reg;
                    mem_wdata.cost     = cand_reg;
                    act_next           = ACT_REPLACED;
                    nh_out_next        = nbr_reg;
                    ifc_out_next       = ifc_reg;
                    cost_out_next      = cand_reg;
                    flag_next          = 1'b1;
                end
                else if ((entry_rd_reg.next_hop == nbr_reg) &&
                         (cand_reg != entry_rd_reg.cost))
                begin
                    mem_we         = 1'b1;
                    mem_wdata.cost = cand_reg;
                    act_next       = ACT_REFRESHED;
                    cost_out_next  = cand_reg;
                    flag_next      = 1'b1;
                end
                state_next = ST_OUT;
            end

            ST_INSERT:
            begin
                if (count_reg < DEPTH_CNT)
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = count_reg[IDX_W-1:0];
                    mem_wdata.dst      = dst_reg;
                    mem_wdata.next_hop = nbr_reg;
                    mem_wdata.iface    = ifc_reg;
                    mem_wdata.cost     = cand_reg;
                    count_next         = count_reg + 1'b1;
                    flag_next          = 1'b1;
                    act_next           = ACT_INSERTED;
                    idx_next           = 6'(count_reg[IDX_W-1:0]);
                    nh_out_next        = nbr_reg;
                    ifc_out_next       = ifc_reg;
                    cost_out_next      = cand_reg;
                end
                else
                begin
                    act_next      = ACT_DROPPED;
                    idx_next      = '0;
                    nh_out_next   = '0;
                    ifc_out_next  = '0;
                    cost_out_next = '0;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                route_out.valid = 1'b1;
                if (route_out.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign route_out.action         = act_reg;
    assign route_out.entry_index    = idx_reg;
    assign route_out.entry_next_hop = nh_out_reg;
    assign route_out.entry_iface    = ifc_out_reg;
    assign route_out.entry_cost     = cost_out_reg;
    assign route_out.round_changed  = flag_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("Entry count exceeds the table depth.");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (count_reg >= $past(count_reg)))
        else $error("Entry count decreased without reset.");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (route_out.valid && (route_out.action == ACT_DROPPED)) |-> (count_reg == DEPTH_CNT))
        else $error("Item dropped while the table had room.");

    a_change_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (route_out.valid && ((route_out.action == ACT_INSERTED) ||
         (route_out.action == ACT_REPLACED) || (route_out.action == ACT_REFRESHED)))
        |-> route_out.round_changed)
        else $error("Table changed without setting the round change flag.");

    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        route_out.valid |-> !route_in.ready)
        else $error("Input ready while a result item is pending.");

endmodule
